/* rtl/core/tfb_pkg.sv */
// tfb_pkg: shared types, constants and the CRC byte update for the frame builder.
// No dependencies; imported by every module of the block.
package tfb_pkg;

    // frame geometry
    localparam int RDG_PER_FRAME = 18;
    localparam int POS_W         = 5;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // byte steps of one frame
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_TS3   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_TS2   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_TS1   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_TS0   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_CNT   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_RD_HI = 4'd5;
    localparam logic [STEP_W-1:0] STEP_RD_LO = 4'd6;
    localparam logic [STEP_W-1:0] STEP_CRC_H = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CRC_L = 4'd8;
    localparam logic [STEP_W-1:0] STEP_TAIL0 = 4'd9;
    localparam logic [STEP_W-1:0] STEP_TAIL1 = 4'd10;
    localparam logic [STEP_W-1:0] STEP_TAIL2 = 4'd11;

    // CRC-16 settings and trailer bytes
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]  TAIL_B0   = 8'hFF;
    localparam logic [7:0]  TAIL_B1   = 8'h00;
    localparam logic [7:0]  TAIL_B2   = 8'h33;

    // one classified reading, front to back
    typedef struct packed {
        logic [31:0] timestamp;
        logic [15:0] reading;
        logic [7:0]  counter;
        logic        first;
        logic        last;
    } t_cmd;

    // queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // MSB-first CRC update over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/tfb_front.sv */
// tfb_front: accepts readings, tracks frame position and the per-second counter.
// Depends on tfb_pkg; pushes one command per word into tfb_queue.
module tfb_front
    import tfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [31:0] i_timestamp,
    input  logic [15:0] i_reading,
    input  t_qstat      i_qstat,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_prev_time, n_prev_time;
    logic [7:0]       r_sec_cnt, n_sec_cnt;
    logic             first, last;

    assign o_push = i_in_valid && !i_qstat.full;

    // classify the word and work out the next frame state
    always_comb begin
        first       = (r_pos == '0);
        last        = ({1'b0, r_pos} + 1'b1) >= (POS_W+1)'(RDG_PER_FRAME);
        n_pos       = r_pos;
        n_prev_time = r_prev_time;
        n_sec_cnt   = r_sec_cnt;
        if (first) begin
            n_prev_time = i_timestamp;
            if (i_timestamp != r_prev_time) begin
                n_sec_cnt = 8'd0;
            end else begin
                n_sec_cnt = r_sec_cnt + 8'd1;
            end
        end
        if (last) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + 1'b1;
        end
    end

    assign o_cmd = '{timestamp: i_timestamp, reading: i_reading,
                     counter: n_sec_cnt, first: first, last: last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_prev_time <= '0;
            r_sec_cnt   <= '0;
        end else if (o_push) begin
            r_pos       <= n_pos;
            r_prev_time <= n_prev_time;
            r_sec_cnt   <= n_sec_cnt;
        end
    end

endmodule

/* rtl/core/tfb_queue.sv */
// tfb_queue: short command queue that decouples the front from the back.
// Depends on tfb_pkg for t_cmd, t_qstat and the depth constants.
module tfb_queue
    import tfb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output t_cmd   o_head,
    output t_qstat o_stat
);

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_slot[r_rptr];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QDEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // payload slots
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full && !do_pop |=> o_stat.full)
        else $error("full queue lost an entry without a pop");
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop && !do_push |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("pop did not lower the count");

endmodule

/* rtl/core/tfb_back.sv */
// tfb_back: serializes queued commands into frame bytes and runs the CRC.
// Depends on tfb_pkg; pulls commands from tfb_queue, drives the output register.
module tfb_back
    import tfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  t_qstat     i_qstat,
    output logic       o_pop,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_frame_last
);

    t_cmd              r_cmd;
    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [15:0]       r_crc;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_run_last, r_frame_last;

    logic              can_emit, emit, at_end;
    logic [STEP_W-1:0] end_step;
    logic [7:0]        cur_byte;

    assign can_emit = !r_out_valid || !i_out_stall;
    assign emit     = r_busy && can_emit;
    assign end_step = r_cmd.last ? STEP_TAIL2 : STEP_RD_LO;
    assign at_end   = (r_step == end_step);
    assign o_pop    = !i_qstat.empty && (!r_busy || (emit && at_end));

    // byte for the current step
    always_comb begin
        unique case (r_step)
            STEP_TS3:   cur_byte = r_cmd.timestamp[31:24];
            STEP_TS2:   cur_byte = r_cmd.timestamp[23:16];
            STEP_TS1:   cur_byte = r_cmd.timestamp[15:8];
            STEP_TS0:   cur_byte = r_cmd.timestamp[7:0];
            STEP_CNT:   cur_byte = r_cmd.counter;
            STEP_RD_HI: cur_byte = r_cmd.reading[15:8];
            STEP_RD_LO: cur_byte = r_cmd.reading[7:0];
            STEP_CRC_H: cur_byte = r_crc[15:8];
            STEP_CRC_L: cur_byte = r_crc[7:0];
            STEP_TAIL0: cur_byte = TAIL_B0;
            STEP_TAIL1: cur_byte = TAIL_B1;
            STEP_TAIL2: cur_byte = TAIL_B2;
            default:    cur_byte = TAIL_B1;
        endcase
    end

    // command register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
    end

    // step sequencer and CRC
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_TS3;
            r_crc  <= CRC_INIT;
        end else begin
            if (emit && !at_end) begin
                r_step <= r_step + 1'b1;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= i_head.first ? STEP_TS3 : STEP_RD_HI;
            end else if (emit && at_end) begin
                r_busy <= 1'b0;
            end
            if (o_pop && i_head.first) begin
                r_crc <= CRC_INIT;
            end else if (emit && r_step <= STEP_RD_LO) begin
                r_crc <= crc_byte(r_crc, cur_byte);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_emit) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte   <= cur_byte;
            r_run_last   <= at_end;
            r_frame_last <= (r_step == STEP_TAIL2);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_run_last   = r_run_last;
    assign o_frame_last = r_frame_last;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step <= end_step)
        else $error("byte step ran past the end of its word");
    a_frame_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_frame_last |-> r_run_last && r_out_byte == TAIL_B2)
        else $error("frame end without closing trailer byte");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_byte))
        else $error("stalled output byte changed");

endmodule

/* rtl/core/telemetry_frame_builder_crc16.sv */
// Telemetry frame builder: readings in, CRC-16 framed byte stream out.
// An accepted word passes a queue slot and the command register to the output.
// Throughput: one output byte per cycle unless stalled; a mid-frame word sends
// reading bytes, a first adds timestamp and counter, a last CRC and trailer.
// The byte-wide output register sets the rate; a 2-entry queue decouples it.
// Reset: synchronous active low; clears position, counter, timestamp, queue.
module telemetry_frame_builder_crc16
    import tfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_timestamp,
    input  logic [15:0] i_reading,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_frame_last
);

    t_cmd   push_cmd, head_cmd;
    t_qstat qstat;
    logic   push, pop;

    assign o_in_stall = qstat.full;

    tfb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_timestamp (i_timestamp),
        .i_reading   (i_reading),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    tfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (qstat)
    );

    tfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_cmd),
        .i_qstat      (qstat),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_frame_last (o_frame_last)
    );

endmodule
